FILE: rtl/core/image_power_of_two_binning_top_macros.svh
// assertion macros for the checker of the binning block
`ifndef IMAGE_POWER_OF_TWO_BINNING_TOP_MACROS_SVH
`define IMAGE_POWER_OF_TWO_BINNING_TOP_MACROS_SVH

// clocked assertion, off while reset is held
`define IPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also checks behavior under reset
`define IPB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/ipb_pkg.sv
`timescale 1ns / 1ps
package ipb_pkg;

  // default size limits
  localparam int unsigned MAX_COLS_DEF   = 1024;
  localparam int unsigned MAX_ROWS_DEF   = 1024;
  localparam int unsigned MAX_PLANES_DEF = 64;

  // field widths
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned SUM_W       = 52;
  localparam int unsigned OUT_ROW_W   = 10;
  localparam int unsigned OUT_COL_W   = 10;
  localparam int unsigned OUT_PLANE_W = 6;
  localparam int unsigned LOG2_W      = 4;
  localparam int unsigned ROWS_REG_W  = 11;
  localparam int unsigned COLS_REG_W  = 11;
  localparam int unsigned PLANES_REG_W = 7;
  localparam int unsigned SHIFT_W     = 5;
  // holds any size up to 4096 and a block size up to 2^15
  localparam int unsigned EXP_W       = 17;

  // apb register map
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [2:0] REG_BIN_ROWS   = 3'd0;
  localparam logic [2:0] REG_BIN_COLS   = 3'd1;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd2;
  localparam logic [2:0] REG_COL_COUNT  = 3'd3;
  localparam logic [2:0] REG_PLANE_CNT  = 3'd4;

  // register reset values
  localparam logic [ROWS_REG_W-1:0]   ROW_COUNT_RST   = 11'd1024;
  localparam logic [COLS_REG_W-1:0]   COL_COUNT_RST   = 11'd1024;
  localparam logic [PLANES_REG_W-1:0] PLANE_COUNT_RST = 7'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] binned_value;
    logic [OUT_ROW_W-1:0]       out_row;
    logic [OUT_COL_W-1:0]       out_col;
    logic [OUT_PLANE_W-1:0]     out_plane;
    logic                       bypassed;
    logic                       last_of_map;
  } out_beat_t;

endpackage

FILE: rtl/core/ipb_stream_if.sv
`timescale 1ns / 1ps
interface ipb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/image_power_of_two_binning_top.sv
`timescale 1ns / 1ps
// Power-of-two pixel binning of a streamed map. Samples arrive plane by plane, row-major, one
// beat per clock; each full block of 2^bin_rows_log2 by 2^bin_cols_log2 samples gives one
// beat holding the block sum arithmetically shifted right by the two exponents. Trailing rows
// and columns that do not fill a block give no beat. With both exponents zero, or a block at
// least as large as its dimension, every sample comes out unchanged with bypassed set. The
// block takes one sample per clock as long as results are taken. The rate is set by the
// read-modify-write of the line memory of partial sums (one entry per output column, one read
// and one write a cycle), with a forwarding register for back-to-back updates of the same
// entry. Registers are to be written over APB only while no map is in flight, which the block
// itself does not enforce; the line memory needs no clearing after reset.
module image_power_of_two_binning_top import ipb_pkg::*; #(
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
  parameter int unsigned MAX_PLANES = MAX_PLANES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ipb_stream_if.sink            in_i,
  ipb_stream_if.source          out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  // configuration registers
  logic [LOG2_W-1:0]       bin_rows_q, bin_cols_q;
  logic [ROWS_REG_W-1:0]   row_cnt_q;
  logic [COLS_REG_W-1:0]   col_cnt_q;
  logic [PLANES_REG_W-1:0] plane_cnt_q;
  logic                    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_rows_q  <= '0;
      bin_cols_q  <= '0;
      row_cnt_q   <= ROW_COUNT_RST;
      col_cnt_q   <= COL_COUNT_RST;
      plane_cnt_q <= PLANE_COUNT_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_BIN_ROWS:  bin_rows_q  <= pwdata[LOG2_W-1:0];
        REG_BIN_COLS:  bin_cols_q  <= pwdata[LOG2_W-1:0];
        REG_ROW_COUNT: row_cnt_q   <= pwdata[ROWS_REG_W-1:0];
        REG_COL_COUNT: col_cnt_q   <= pwdata[COLS_REG_W-1:0];
        REG_PLANE_CNT: plane_cnt_q <= pwdata[PLANES_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_BIN_ROWS:  prdata = APB_DATA_W'(bin_rows_q);
      REG_BIN_COLS:  prdata = APB_DATA_W'(bin_cols_q);
      REG_ROW_COUNT: prdata = APB_DATA_W'(row_cnt_q);
      REG_COL_COUNT: prdata = APB_DATA_W'(col_cnt_q);
      REG_PLANE_CNT: prdata = APB_DATA_W'(plane_cnt_q);
      default:       prdata = '0;
    endcase
  end

  // sizes saturated to [1, max]
  logic [EXP_W-1:0] rows, cols, planes;

  always_comb begin
    if (row_cnt_q == '0) begin
      rows = EXP_W'(1);
    end else if (EXP_W'(row_cnt_q) > EXP_W'(MAX_ROWS)) begin
      rows = EXP_W'(MAX_ROWS);
    end else begin
      rows = EXP_W'(row_cnt_q);
    end
    if (col_cnt_q == '0) begin
      cols = EXP_W'(1);
    end else if (EXP_W'(col_cnt_q) > EXP_W'(MAX_COLS)) begin
      cols = EXP_W'(MAX_COLS);
    end else begin
      cols = EXP_W'(col_cnt_q);
    end
    if (plane_cnt_q == '0) begin
      planes = EXP_W'(1);
    end else if (EXP_W'(plane_cnt_q) > EXP_W'(MAX_PLANES)) begin
      planes = EXP_W'(MAX_PLANES);
    end else begin
      planes = EXP_W'(plane_cnt_q);
    end
  end

  // position counters
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [PW-1:0] plane_q, plane_d;

  // stage 0 decode of the incoming sample position
  logic [EXP_W-1:0] bh, bw, rmask, cmask, rows_full, cols_full;
  logic [EXP_W-1:0] r_ext, c_ext, p_ext, r1, c1, p1;
  logic             bypass, in_range, blk_first, blk_end, last_byp, last_bin;
  logic [CW-1:0]    idx;

  assign bh        = EXP_W'(1) << bin_rows_q;
  assign bw        = EXP_W'(1) << bin_cols_q;
  assign rmask     = bh - EXP_W'(1);
  assign cmask     = bw - EXP_W'(1);
  assign rows_full = rows & ~rmask;
  assign cols_full = cols & ~cmask;
  assign r_ext     = EXP_W'(row_q);
  assign c_ext     = EXP_W'(col_q);
  assign p_ext     = EXP_W'(plane_q);
  assign r1        = r_ext + EXP_W'(1);
  assign c1        = c_ext + EXP_W'(1);
  assign p1        = p_ext + EXP_W'(1);

  assign bypass    = ((bin_rows_q == '0) && (bin_cols_q == '0)) || (bh >= rows) || (bw >= cols);
  assign in_range  = (r_ext < rows_full) && (c_ext < cols_full);
  assign blk_first = ((r_ext & rmask) == '0) && ((c_ext & cmask) == '0);
  assign blk_end   = ((r_ext & rmask) == rmask) && ((c_ext & cmask) == cmask);
  assign last_byp  = (r1 == rows) && (c1 == cols) && (p1 == planes);
  assign last_bin  = (r1 == rows_full) && (c1 == cols_full) && (p1 == planes);
  assign idx       = CW'(col_q >> bin_cols_q);

  // counter advance, wrapping at or past the limits
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    plane_d = plane_q;
    if (c1 >= cols) begin
      col_d = '0;
      if (r1 >= rows) begin
        row_d = '0;
        if (p1 >= planes) begin
          plane_d = '0;
        end else begin
          plane_d = PW'(p1);
        end
      end else begin
        row_d = RW'(r1);
      end
    end else begin
      col_d = CW'(c1);
    end
  end

  // pipeline handshake
  logic s1_valid_q, s1_wr_q, s1_emit_q, s1_adv, in_acc, in_ready;
  logic out_valid_q, out_load;

  assign s1_adv   = s1_valid_q && (!s1_emit_q || !out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_ready;
  assign out_load = s1_adv && s1_emit_q;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      plane_q <= '0;
    end else if (in_acc) begin
      row_q   <= row_d;
      col_q   <= col_d;
      plane_q <= plane_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_wr_q     <= 1'b0;
      s1_emit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_wr_q    <= !bypass && in_range;
        s1_emit_q  <= bypass || (in_range && blk_end);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage 1 payload
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [CW-1:0]              s1_idx_q;
  logic                       s1_first_q, s1_byp_q, s1_last_q, fwd_q;
  logic [OUT_ROW_W-1:0]       s1_row_q;
  logic [OUT_COL_W-1:0]       s1_col_q;
  logic [OUT_PLANE_W-1:0]     s1_plane_q;
  logic [SHIFT_W-1:0]         s1_shift_q;
  logic [SUM_W-1:0]           fwd_data_q, rdata_q, s1_oper, s1_sum;
  logic signed [SAMPLE_W-1:0] s1_avg;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= in_i.data.sample;
      s1_idx_q    <= idx;
      s1_first_q  <= blk_first;
      s1_byp_q    <= bypass;
      s1_shift_q  <= SHIFT_W'(bin_rows_q) + SHIFT_W'(bin_cols_q);
      s1_plane_q  <= OUT_PLANE_W'(plane_q);
      if (bypass) begin
        s1_row_q  <= OUT_ROW_W'(row_q);
        s1_col_q  <= OUT_COL_W'(col_q);
        s1_last_q <= last_byp;
      end else begin
        s1_row_q  <= OUT_ROW_W'(row_q >> bin_rows_q);
        s1_col_q  <= OUT_COL_W'(col_q >> bin_cols_q);
        s1_last_q <= last_bin;
      end
      // the write of the item ahead lands at this same edge
      fwd_q      <= s1_adv && s1_wr_q && (s1_idx_q == idx);
      fwd_data_q <= s1_sum;
    end
  end

  // line memory of partial sums, read at accept, written when stage 1 retires
  logic [SUM_W-1:0] line_mem [MAX_COLS];

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_wr_q) begin
      line_mem[s1_idx_q] <= s1_sum;
    end
    if (in_acc) begin
      rdata_q <= line_mem[idx];
    end
  end

  // accumulate and average
  assign s1_oper = s1_first_q ? '0 : (fwd_q ? fwd_data_q : rdata_q);
  assign s1_sum  = s1_oper + {{(SUM_W-SAMPLE_W){s1_sample_q[SAMPLE_W-1]}}, s1_sample_q};
  assign s1_avg  = SAMPLE_W'($signed(s1_sum) >>> s1_shift_q);

  // output register
  out_beat_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.binned_value <= s1_byp_q ? s1_sample_q : s1_avg;
      out_data_q.out_row      <= s1_row_q;
      out_data_q.out_col      <= s1_col_q;
      out_data_q.out_plane    <= s1_plane_q;
      out_data_q.bypassed     <= s1_byp_q;
      out_data_q.last_of_map  <= s1_last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

FILE: rtl/core/ipb_checker.sv
`timescale 1ns / 1ps
`include "image_power_of_two_binning_top_macros.svh"
module ipb_checker import ipb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_beat_t out_data_i
);

  // no result beat right after reset
  `IPB_ASSERT_RST(a_rst_out_idle, !rst_ni |=> !out_valid_i, "result valid after reset")

  // a stalled result beat holds
  `IPB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result beat changed under stall")

  // a fresh result traces back to an accepted sample, through stage 1 into the output register
  `IPB_ASSERT(a_out_cause, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2), "result without a sample")

  // an empty output stage never holds back the input
  `IPB_ASSERT(a_ready_free, !out_valid_i |-> in_ready_i, "input stalled with empty output")

endmodule

bind image_power_of_two_binning_top ipb_checker u_ipb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
